### rtl/packbits_rle_encoder_crc32_assert.svh
// Assertion macros used by the encoder top level.
`ifndef PACKBITS_RLE_ENCODER_CRC32_ASSERT_SVH
`define PACKBITS_RLE_ENCODER_CRC32_ASSERT_SVH

// Same-cycle implication under the active-low reset.
`define PBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("encoder assertion failed");

// Next-cycle implication under the active-low reset.
`define PBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("encoder assertion failed");

`endif

### rtl/pbr_pkg.sv
// Package of types, constants and CRC helpers for the PackBits encoder.
package pbr_pkg;

    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [7:0]  MIN_RUN_RST = 8'd3;
    localparam logic [3:0]  NIB_MASK    = 4'hF;

    // Kind of one emission phase.
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_RUN  = 2'd1,
        K_LIT  = 2'd2
    } t_kind;

    // Controller states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EVAL    = 7'b0000010,
        S_P1_HDR  = 7'b0000100,
        S_P1_BODY = 7'b0001000,
        S_WR      = 7'b0010000,
        S_P2_HDR  = 7'b0100000,
        S_P2_BODY = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;
        logic accept;
        logic eval;
        logic store_wr;
        logic emit;
        logic phase2;
        logic body;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic p1_any;
        logic eos;
        logic push_ok;
        logic body_last;
    } t_status;

    // Table of nibble remainders for the reflected polynomial.
    function automatic logic [31:0] nib_rem(input logic [3:0] n);
        logic [31:0] c;
        c = {28'd0, n};
        for (int i = 0; i < 4; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // One byte into the CRC, low nibble first.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] t;
        t = nib_rem((c[3:0] ^ b[3:0]) & NIB_MASK) ^ (c >> 4);
        t = nib_rem((t[3:0] ^ b[7:4]) & NIB_MASK) ^ (t >> 4);
        return t;
    endfunction

endpackage

### rtl/pbr_in_if.sv
// Input channel: one source byte per beat.
interface pbr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### rtl/pbr_out_if.sv
// Output channel: up to eight encoded bytes per beat.
interface pbr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  out_count;
    logic        last_of_run;
    logic        crc_valid;
    logic [31:0] crc_value;

    modport source (output valid, output out_bytes, output out_count, output last_of_run,
                    output crc_valid, output crc_value, input ready);
    modport sink   (input valid, input out_bytes, input out_count, input last_of_run,
                    input crc_valid, input crc_value, output ready);
endinterface

### rtl/pbr_cfg_if.sv
// Configuration write channel for the min_run register.
interface pbr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/pbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/pbr_ctrl.sv
// Controller state machine sequencing evaluation, store write and emission.
module pbr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pbr_pkg::t_status i_status,
    output pbr_pkg::t_cmd    o_cmd
);
    pbr_pkg::t_state r_state, n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pbr_pkg::S_EVAL;
            end
            pbr_pkg::S_EVAL: begin
                if (i_status.p1_any)   n_state = pbr_pkg::S_P1_HDR;
                else if (i_status.eos) n_state = pbr_pkg::S_P2_HDR;
                else                   n_state = pbr_pkg::S_IDLE;
            end
            pbr_pkg::S_P1_HDR: begin
                if (i_status.push_ok) n_state = pbr_pkg::S_P1_BODY;
            end
            pbr_pkg::S_P1_BODY: begin
                if (i_status.push_ok && i_status.body_last) n_state = pbr_pkg::S_WR;
            end
            pbr_pkg::S_WR: begin
                n_state = i_status.eos ? pbr_pkg::S_P2_HDR : pbr_pkg::S_IDLE;
            end
            pbr_pkg::S_P2_HDR: begin
                if (i_status.push_ok) n_state = pbr_pkg::S_P2_BODY;
            end
            pbr_pkg::S_P2_BODY: begin
                if (i_status.push_ok && i_status.body_last) n_state = pbr_pkg::S_IDLE;
            end
            default: n_state = pbr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pbr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode.
    always_comb begin
        o_cmd.ready    = (r_state == pbr_pkg::S_IDLE);
        o_cmd.accept   = (r_state == pbr_pkg::S_IDLE) && i_in_valid;
        o_cmd.eval     = (r_state == pbr_pkg::S_EVAL);
        o_cmd.store_wr = ((r_state == pbr_pkg::S_EVAL) && !i_status.p1_any)
                         || (r_state == pbr_pkg::S_WR);
        o_cmd.emit     = (r_state == pbr_pkg::S_P1_HDR) || (r_state == pbr_pkg::S_P1_BODY)
                         || (r_state == pbr_pkg::S_P2_HDR) || (r_state == pbr_pkg::S_P2_BODY);
        o_cmd.phase2   = (r_state == pbr_pkg::S_P2_HDR) || (r_state == pbr_pkg::S_P2_BODY);
        o_cmd.body     = (r_state == pbr_pkg::S_P1_BODY) || (r_state == pbr_pkg::S_P2_BODY);
    end
endmodule

### rtl/pbr_datapath.sv
// Datapath: encoder state, CRC, literal store, byte selection and result packing.
module pbr_datapath #(
    parameter int MAX_BLOCK        = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pbr_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_stream,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_out_ready,
    output pbr_pkg::t_status o_status,
    output logic             o_out_valid,
    output logic [63:0]      o_out_bytes,
    output logic [3:0]       o_out_count,
    output logic             o_out_last,
    output logic             o_out_crc_valid,
    output logic [31:0]      o_out_crc_value
);
    localparam int LW = $clog2(MAX_BLOCK + 2);
    localparam int AW = $clog2(MAX_BLOCK);
    localparam logic [LW-1:0] MAXL = LW'(MAX_BLOCK);
    localparam logic [3:0]    BPR  = 4'(BYTES_PER_RESULT);

    // Encoder state.
    logic          r_started, r_in_run;
    logic [LW-1:0] r_pend, r_tail;
    logic [7:0]    r_prev, r_min_run, r_cur;
    logic [31:0]   r_crc, r_crc_out;
    logic          r_eos;

    // Latched decisions for the emission phases.
    pbr_pkg::t_kind r_p1_kind;
    logic [LW-1:0]  r_p1_len, r_p2_len;
    logic [7:0]     r_p1_byte;
    logic           r_p2_run, r_we;
    logic [AW-1:0]  r_waddr, r_idx, n_idx;

    // Evaluation results.
    logic           n_in_run;
    logic [LW-1:0]  c_p, n_pend, n_tail, n_p1_len;
    pbr_pkg::t_kind n_p1_kind;
    logic [31:0]    n_crc;

    // Packer and result register.
    logic [63:0] r_acc, r_obytes;
    logic [3:0]  r_acc_cnt, r_ocnt;
    logic        r_ovalid, r_olast, r_ocrcv;
    logic [31:0] r_ocrc;

    logic [7:0]     w_rdata, w_byte;
    logic           w_ram_we, w_push, w_final, w_body_last, w_flush;
    logic [AW-1:0]  w_waddr;
    pbr_pkg::t_kind w_kind;
    logic [LW-1:0]  w_len;
    logic [63:0]    w_acc_new;
    logic [3:0]     w_cnt_new;

    // Decision for the byte just accepted.
    always_comb begin
        c_p       = r_started ? (r_pend + LW'(1)) : LW'(1);
        n_in_run  = r_in_run;
        n_pend    = c_p;
        n_tail    = r_tail;
        n_p1_kind = pbr_pkg::K_NONE;
        n_p1_len  = r_pend;
        if (!r_started) begin
            n_in_run = 1'b0;
            n_pend   = LW'(1);
            n_tail   = '0;
        end else if (r_in_run) begin
            if ((r_cur != r_prev) || (c_p > MAXL)) begin
                n_p1_kind = pbr_pkg::K_RUN;
                n_p1_len  = r_pend;
                n_pend    = LW'(1);
                n_tail    = '0;
                n_in_run  = 1'b0;
            end
        end else if (c_p > MAXL) begin
            n_p1_kind = pbr_pkg::K_LIT;
            n_p1_len  = MAXL;
            n_pend    = c_p - MAXL;
            n_tail    = c_p - MAXL - LW'(1);
        end else if (r_cur == r_prev) begin
            if ((r_tail == '0) || (8'(c_p - r_tail) >= r_min_run)) begin
                if (r_tail != '0) begin
                    n_p1_kind = pbr_pkg::K_LIT;
                    n_p1_len  = r_tail;
                end
                n_pend   = c_p - r_tail;
                n_in_run = 1'b1;
            end
        end else begin
            n_tail = c_p - LW'(1);
        end
    end

    assign n_crc = pbr_pkg::crc_byte(r_crc, r_cur);

    // State registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_in_run  <= 1'b0;
            r_pend    <= '0;
            r_tail    <= '0;
            r_prev    <= '0;
            r_crc     <= pbr_pkg::CRC_INIT;
            r_min_run <= pbr_pkg::MIN_RUN_RST;
        end else begin
            if (i_cfg_we) r_min_run <= i_cfg_data;
            if (i_cmd.eval) begin
                if (r_eos) begin
                    r_started <= 1'b0;
                    r_in_run  <= 1'b0;
                    r_pend    <= '0;
                    r_tail    <= '0;
                    r_prev    <= '0;
                    r_crc     <= pbr_pkg::CRC_INIT;
                end else begin
                    r_started <= 1'b1;
                    r_in_run  <= n_in_run;
                    r_pend    <= n_pend;
                    r_tail    <= n_tail;
                    r_prev    <= r_cur;
                    r_crc     <= n_crc;
                end
            end
        end
    end

    // Phase decisions and captured input; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cur <= i_data_byte;
            r_eos <= i_end_of_stream;
        end
        if (i_cmd.eval) begin
            r_p1_kind <= n_p1_kind;
            r_p1_len  <= n_p1_len;
            r_p1_byte <= r_prev;
            r_p2_run  <= n_in_run;
            r_p2_len  <= n_pend;
            r_we      <= !n_in_run;
            r_waddr   <= AW'(n_pend - LW'(1));
            r_crc_out <= ~n_crc;
        end
        r_idx <= n_idx;
    end

    // Literal store.
    assign w_ram_we = i_cmd.store_wr && (i_cmd.eval ? !n_in_run : r_we);
    assign w_waddr  = i_cmd.eval ? AW'(n_pend - LW'(1)) : r_waddr;

    pbr_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_cur),
        .i_raddr (n_idx),
        .o_rdata (w_rdata)
    );

    // Byte selection for the current phase.
    always_comb begin
        w_kind = i_cmd.phase2 ? (r_p2_run ? pbr_pkg::K_RUN : pbr_pkg::K_LIT) : r_p1_kind;
        w_len  = i_cmd.phase2 ? r_p2_len : r_p1_len;
        if (!i_cmd.body) begin
            w_byte = (w_kind == pbr_pkg::K_RUN) ? (8'd1 - 8'(w_len)) : (8'(w_len) - 8'd1);
        end else if (w_kind == pbr_pkg::K_RUN) begin
            w_byte = i_cmd.phase2 ? r_cur : r_p1_byte;
        end else begin
            w_byte = w_rdata;
        end
        w_body_last = (w_kind == pbr_pkg::K_RUN) || (r_idx == AW'(w_len - LW'(1)));
        w_final     = i_cmd.body && w_body_last && (i_cmd.phase2 || !r_eos);
    end

    assign w_push = i_cmd.emit && (!r_ovalid || i_out_ready);

    // Read address runs one byte ahead of the body.
    always_comb begin
        if (i_cmd.emit && !i_cmd.body) begin
            n_idx = '0;
        end else if (w_push && i_cmd.body) begin
            n_idx = r_idx + AW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Packing of bytes into results.
    assign w_acc_new = r_acc | ({56'd0, w_byte} << {r_acc_cnt[2:0], 3'b000});
    assign w_cnt_new = r_acc_cnt + 4'd1;
    assign w_flush   = w_push && ((w_cnt_new == BPR) || w_final);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_acc_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (w_flush) begin
                r_acc     <= '0;
                r_acc_cnt <= '0;
            end else if (w_push) begin
                r_acc     <= w_acc_new;
                r_acc_cnt <= w_cnt_new;
            end
            if (w_flush)          r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_flush) begin
            r_obytes <= w_acc_new;
            r_ocnt   <= w_cnt_new;
            r_olast  <= w_final;
            r_ocrcv  <= w_final && i_cmd.phase2;
            r_ocrc   <= (w_final && i_cmd.phase2) ? r_crc_out : 32'd0;
        end
    end

    assign o_status.p1_any    = (n_p1_kind != pbr_pkg::K_NONE);
    assign o_status.eos       = r_eos;
    assign o_status.push_ok   = !r_ovalid || i_out_ready;
    assign o_status.body_last = w_body_last;

    assign o_out_valid     = r_ovalid;
    assign o_out_bytes     = r_obytes;
    assign o_out_count     = r_ocnt;
    assign o_out_last      = r_olast;
    assign o_out_crc_valid = r_ocrcv;
    assign o_out_crc_value = r_ocrc;
endmodule

### rtl/packbits_rle_encoder_crc32.sv
// Top level of the PackBits run-length encoder with CRC-32 of its input.
//
// Channels: i_in takes one source byte per beat with an end_of_stream flag on
// the final byte; o_out gives up to eight encoded bytes per beat, first byte
// in bits 7:0, with last_of_run on the final beat caused by an input byte and
// crc_valid with the inverted CRC-32 on the final beat of a stream; i_cfg
// writes min_run at any beat and is always ready.
// Sequence: a byte that emits nothing is accepted and then evaluated. Bytes
// that emit output then pass through a header and a body state per phase,
// with a store write state between the phases when a block was flushed first.
// The emission rate is set by the single read port of the literal store,
// one byte per cycle while the output register can take a new result.
// Results appear in the output register in the cycle after their last byte.
// Reset clears the encoder state and the CRC and sets min_run to 3; the store
// needs no clearing. When the receiver stalls with a result waiting, emission
// halts in place and resumes without loss once the beat is taken.
module packbits_rle_encoder_crc32 #(
    parameter int MAX_BLOCK        = 128,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbr_in_if.sink     i_in,
    pbr_out_if.source  o_out,
    pbr_cfg_if.sink    i_cfg
);
    `include "packbits_rle_encoder_crc32_assert.svh"

    pbr_pkg::t_cmd    w_cmd;
    pbr_pkg::t_status w_status;

    assign i_in.ready  = w_cmd.ready;
    assign i_cfg.ready = 1'b1;

    pbr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pbr_datapath #(
        .MAX_BLOCK        (MAX_BLOCK),
        .BYTES_PER_RESULT (BYTES_PER_RESULT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_stream (i_in.end_of_stream),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_out.ready),
        .o_status        (w_status),
        .o_out_valid     (o_out.valid),
        .o_out_bytes     (o_out.out_bytes),
        .o_out_count     (o_out.out_count),
        .o_out_last      (o_out.last_of_run),
        .o_out_crc_valid (o_out.crc_valid),
        .o_out_crc_value (o_out.crc_value)
    );

    // An accepted beat is always evaluated in the following cycle.
    `PBR_ASSERT_NEXT(a_eval_follows, i_in.valid && i_in.ready, w_cmd.eval)
    // No new byte is taken while one is being worked on.
    `PBR_ASSERT_NOW(a_busy_not_ready, w_cmd.eval || w_cmd.emit, !i_in.ready)
    // A result never carries zero bytes or more than a full beat.
    `PBR_ASSERT_NOW(a_count_range, o_out.valid,
        (o_out.out_count != 4'd0) && (o_out.out_count <= 4'(BYTES_PER_RESULT)))
    // The finished CRC only rides on the last beat of an input byte.
    `PBR_ASSERT_NOW(a_crc_on_last, o_out.valid && o_out.crc_valid, o_out.last_of_run)
endmodule
